FILE: hw/rtl/rpns_pkg.sv
// Package for the RPN operand stack: beat types, command codes and the
// per-cell shift control. No dependencies.
`timescale 1ns / 1ps

package rpns_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned WordWidthDef  = 64;

  typedef enum logic [3:0] {
    CMD_PUSH     = 4'd0,
    CMD_DUP      = 4'd1,
    CMD_SWAP     = 4'd2,
    CMD_ROT      = 4'd3,
    CMD_OVER     = 4'd4,
    CMD_DROP     = 4'd5,
    CMD_CLEAR    = 4'd6,
    CMD_DROP_NTH = 4'd7,
    CMD_REDUCE   = 4'd8
  } cmd_e;

  // What every cell does this cycle (cells below load_n only)
  typedef enum logic [2:0] {
    SH_HOLD     = 3'd0,
    SH_DOWN     = 3'd1,
    SH_UP       = 3'd2,
    SH_UP2      = 3'd3,
    SH_CLEAR    = 3'd4,
    SH_DROP_NTH = 3'd5
  } shift_e;

  typedef struct packed {
    shift_e      shift;
    logic [1:0]  load_n;   // cells 0..load_n-1 take their load word
    logic [3:0]  pos;      // drop_nth position
  } cell_ctrl_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [63:0] value;
    logic [1:0]  operand_count;
    logic [3:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [63:0] top_word;
    logic [63:0] second_word;
    logic [4:0]  depth;
  } out_beat_t;

endpackage

FILE: hw/rtl/rpn_operand_stack.sv
// Top level of the RPN operand stack: command decode, a row of cells and
// the result beat. Depends on rpns_pkg, rpns_ctrl and rpns_cell.
`timescale 1ns / 1ps

//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_beat_t  (command, operands)
//  out     | output    | out_valid_o / out_ready_i | out_beat_t (status, top two, depth)
//
//  For every command the whole row of cells shifts or loads at the edge that
//  accepts the beat, and the result is valid in the next cycle.
//  A new beat is taken in the same cycle the previous result is taken, so
//  the stack sustains one command per cycle while out_ready_i stays high.
//  Reset clears all cells and the fill count; the stack starts empty.
//  While a result is stalled, in_ready_o is low and the cells hold.

module rpn_operand_stack #(
  parameter int unsigned STACK_DEPTH = rpns_pkg::StackDepthDef,
  parameter int unsigned WORD_WIDTH  = rpns_pkg::WordWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rpns_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rpns_pkg::out_beat_t out_data_o
);
  import rpns_pkg::*;

  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(STACK_DEPTH);

  logic                  accept;
  logic [FillW-1:0]      fill_d, fill_q;
  logic                  status_d, status_q;
  logic                  out_valid_q;
  cell_ctrl_t            cell_ctrl;
  logic [WORD_WIDTH-1:0] load_w [3];
  logic [IdxW-1:0]       last_idx;
  logic [WORD_WIDTH-1:0] cell_w [STACK_DEPTH];

  // Output slot frees up in the cycle its beat is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  rpns_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_ctrl (
    .accept_i   (accept),
    .beat_i     (in_data_i),
    .fill_i     (fill_q),
    .c0_i       (cell_w[0]),
    .c1_i       (cell_w[1]),
    .c2_i       (cell_w[2]),
    .ctrl_o     (cell_ctrl),
    .load_o     (load_w),
    .last_idx_o (last_idx),
    .fill_o     (fill_d),
    .status_o   (status_d)
  );

  // Row of cells, cell 0 is the top. Zero enters past either end, which
  // keeps cells at or below the fill count at zero.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] above, below, below2, load;

    if (i == 0) begin : g_top
      assign above = '0;
    end else begin : g_mid
      assign above = cell_w[i-1];
    end

    if (i + 1 < STACK_DEPTH) begin : g_b1
      assign below = cell_w[i+1];
    end else begin : g_b1_end
      assign below = '0;
    end

    if (i + 2 < STACK_DEPTH) begin : g_b2
      assign below2 = cell_w[i+2];
    end else begin : g_b2_end
      assign below2 = '0;
    end

    if (i < 3) begin : g_ld
      assign load = load_w[i];
    end else begin : g_no_ld
      assign load = '0;
    end

    rpns_cell #(
      .STACK_DEPTH (STACK_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .last_idx_i (last_idx),
      .above_i    (above),
      .below_i    (below),
      .below2_i   (below2),
      .load_i     (load),
      .word_o     (cell_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Cells and fill count only move on an accepted beat, so they are the
  // result until the next one is taken.
  assign out_valid_o            = out_valid_q;
  assign out_data_o.status      = status_q;
  assign out_data_o.top_word    = 64'(cell_w[0]);
  assign out_data_o.second_word = 64'(cell_w[1]);
  assign out_data_o.depth       = 5'(fill_q);

endmodule

FILE: hw/rtl/rpns_cell.sv
// One stack cell: holds a word and picks its next value from its neighbors.
// Depends on rpns_pkg.
`timescale 1ns / 1ps

module rpns_cell #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned WORD_WIDTH  = 64,
  parameter int unsigned IDX         = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rpns_pkg::cell_ctrl_t           ctrl_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] last_idx_i,
  input  logic [WORD_WIDTH-1:0]          above_i,
  input  logic [WORD_WIDTH-1:0]          below_i,
  input  logic [WORD_WIDTH-1:0]          below2_i,
  input  logic [WORD_WIDTH-1:0]          load_i,
  output logic [WORD_WIDTH-1:0]          word_o
);
  import rpns_pkg::*;

  localparam int unsigned Idx = IDX;

  logic [WORD_WIDTH-1:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    if (Idx < 32'(ctrl_i.load_n)) begin
      word_d = load_i;
    end else begin
      case (ctrl_i.shift)
        SH_HOLD:  word_d = word_q;
        SH_DOWN:  word_d = above_i;
        SH_UP:    word_d = below_i;
        SH_UP2:   word_d = below2_i;
        SH_CLEAR: word_d = '0;
        SH_DROP_NTH: begin
          if (Idx >= 32'(ctrl_i.pos)) begin
            word_d = below_i;
          end else if (Idx == 32'(last_idx_i)) begin
            word_d = '0;   // position past live cells: deepest one is lost
          end
        end
        default:  word_d = word_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

FILE: hw/rtl/rpns_ctrl.sv
// Command decode: turns one input beat into cell controls, load words,
// next fill count and status. Depends on rpns_pkg.
`timescale 1ns / 1ps

module rpns_ctrl #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned WORD_WIDTH  = 64
) (
  input  logic                             accept_i,
  input  rpns_pkg::in_beat_t               beat_i,
  input  logic [$clog2(STACK_DEPTH+1)-1:0] fill_i,
  input  logic [WORD_WIDTH-1:0]            c0_i,
  input  logic [WORD_WIDTH-1:0]            c1_i,
  input  logic [WORD_WIDTH-1:0]            c2_i,
  output rpns_pkg::cell_ctrl_t             ctrl_o,
  output logic [WORD_WIDTH-1:0]            load_o [3],
  output logic [$clog2(STACK_DEPTH)-1:0]   last_idx_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0] fill_o,
  output logic                             status_o
);
  import rpns_pkg::*;

  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(STACK_DEPTH);

  logic                  full;
  logic [WORD_WIDTH-1:0] val;
  logic [FillW-1:0]      cnt;
  logic [FillW-1:0]      fill_pop;
  logic [FillW-1:0]      fill_m1;
  cmd_e                  cmd;

  assign full     = (fill_i == FillW'(STACK_DEPTH));
  assign val      = beat_i.value[WORD_WIDTH-1:0];
  assign cnt      = FillW'(beat_i.operand_count);
  assign fill_pop = (fill_i > cnt) ? fill_i - cnt : '0;
  assign fill_m1  = fill_i - FillW'(1);
  assign cmd      = cmd_e'(beat_i.command);
  assign last_idx_o = fill_m1[IdxW-1:0];

  always_comb begin
    ctrl_o.shift  = SH_HOLD;
    ctrl_o.load_n = 2'd0;
    ctrl_o.pos    = beat_i.position;
    load_o[0]     = '0;
    load_o[1]     = '0;
    load_o[2]     = '0;
    fill_o        = fill_i;
    status_o      = 1'b0;
    if (accept_i) begin
      unique case (cmd) inside
        CMD_PUSH, CMD_DUP, CMD_OVER: begin
          if (full) begin
            status_o = 1'b1;
          end else begin
            ctrl_o.shift  = SH_DOWN;
            ctrl_o.load_n = 2'd1;
            load_o[0]     = (cmd == CMD_PUSH) ? val : ((cmd == CMD_DUP) ? c0_i : c1_i);
            fill_o        = fill_i + FillW'(1);
          end
        end
        CMD_SWAP: begin
          ctrl_o.load_n = 2'd2;
          load_o[0]     = c1_i;
          load_o[1]     = c0_i;
          fill_o        = (fill_i < FillW'(2)) ? FillW'(2) : fill_i;
        end
        CMD_ROT: begin
          ctrl_o.load_n = 2'd3;
          load_o[0]     = c2_i;
          load_o[1]     = c0_i;
          load_o[2]     = c1_i;
          fill_o        = (fill_i < FillW'(3)) ? FillW'(3) : fill_i;
        end
        CMD_DROP: begin
          ctrl_o.shift = SH_UP;
          if (fill_i != '0) begin
            fill_o = fill_m1;
          end
        end
        CMD_CLEAR: begin
          ctrl_o.shift = SH_CLEAR;
          fill_o       = '0;
        end
        CMD_DROP_NTH: begin
          if (fill_i != '0) begin
            ctrl_o.shift = SH_DROP_NTH;
            fill_o       = fill_m1;
          end
        end
        CMD_REDUCE: begin
          if (full && (cnt == '0)) begin
            status_o = 1'b1;
          end else begin
            // net movement: pops minus the final push
            case (beat_i.operand_count)
              2'd0:    ctrl_o.shift = SH_DOWN;
              2'd1:    ctrl_o.shift = SH_HOLD;
              2'd2:    ctrl_o.shift = SH_UP;
              default: ctrl_o.shift = SH_UP2;
            endcase
            ctrl_o.load_n = 2'd1;
            load_o[0]     = val;
            fill_o        = fill_pop + FillW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
